@@ sv/pdvl_pkg.sv @@
// ----------------------------------------------------------------------------
// pdvl_pkg
// Shared widths, control word layout, microprogram and saturation helper for
// the two-axis PD velocity loop.
// ----------------------------------------------------------------------------
package pdvl_pkg;

   localparam int CmdW     = 16;
   localparam int VelW     = 16;
   localparam int GainW    = 24;
   localparam int ScaleW   = 32;
   localparam int FracW    = 16;
   localparam int MulAW    = 32;
   localparam int MulBW    = 17;
   localparam int ProdW    = MulAW + MulBW;
   localparam int AccW     = 43;
   localparam int WideW    = 34;
   localparam int StepW    = 4;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;

   localparam logic [StepW-1:0] StepOutX = 4'd5;
   localparam logic [StepW-1:0] StepOutY = 4'd11;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_SCALE,
      MUL_KP,
      MUL_KD
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KP_X,
      CSR_KP_Y,
      CSR_KD_X,
      CSR_KD_Y,
      CSR_SCALE_X,
      CSR_SCALE_Y,
      CSR_DERIV_EN
   } csr_idx_type;

   typedef struct packed {
      mul_sel_type      mul_sel;
      acc_op_type       acc_op;
      logic             err_load;
      logic             prev_load;
      logic             out_load;
      logic             axis;
      logic             jmp_nod;
      logic [StepW-1:0] target;
      logic             last;
   } ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

   function automatic ctl_type ucode(input logic [StepW-1:0] step);
      ctl_type w;
      w = '0;
      unique case (step)
         4'd0: begin
            w.mul_sel = MUL_SCALE;
         end
         4'd1: begin
            w.err_load = 1'b1;
            w.acc_op   = ACC_LOAD;
         end
         4'd2: begin
            w.mul_sel = MUL_KP;
         end
         4'd3: begin
            w.acc_op  = ACC_ADD;
            w.mul_sel = MUL_KD;
            w.jmp_nod = 1'b1;
            w.target  = StepOutX;
         end
         4'd4: begin
            w.acc_op    = ACC_ADD;
            w.prev_load = 1'b1;
         end
         4'd5: begin
            w.out_load = 1'b1;
         end
         4'd6: begin
            w.axis    = 1'b1;
            w.mul_sel = MUL_SCALE;
         end
         4'd7: begin
            w.axis     = 1'b1;
            w.err_load = 1'b1;
            w.acc_op   = ACC_LOAD;
         end
         4'd8: begin
            w.axis    = 1'b1;
            w.mul_sel = MUL_KP;
         end
         4'd9: begin
            w.axis    = 1'b1;
            w.acc_op  = ACC_ADD;
            w.mul_sel = MUL_KD;
            w.jmp_nod = 1'b1;
            w.target  = StepOutY;
         end
         4'd10: begin
            w.axis      = 1'b1;
            w.acc_op    = ACC_ADD;
            w.prev_load = 1'b1;
         end
         4'd11: begin
            w.axis     = 1'b1;
            w.out_load = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

   // {clip, value}
   function automatic logic [CmdW:0] sat16(input logic signed [WideW-1:0] v);
      logic [CmdW:0] r;
      if (v > WideW'(signed'(32767))) begin
         r = {1'b1, 16'h7fff};
      end else if (v < -WideW'(signed'(32768))) begin
         r = {1'b1, 16'h8000};
      end else begin
         r = {1'b0, v[CmdW-1:0]};
      end
      return r;
   endfunction

endpackage

@@ sv/pdvl_if.sv @@
// ----------------------------------------------------------------------------
// pdvl_if
// Valid/ready channels of the PD velocity loop: request, response and
// register write.
// ----------------------------------------------------------------------------
interface pdvl_req_if import pdvl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [CmdW-1:0] cmd_x;
   logic signed [CmdW-1:0] cmd_y;
   logic signed [VelW-1:0] vel_x;
   logic signed [VelW-1:0] vel_y;
   modport source (output valid, cmd_x, cmd_y, vel_x, vel_y, input ready);
   modport sink (input valid, cmd_x, cmd_y, vel_x, vel_y, output ready);
endinterface

interface pdvl_rsp_if import pdvl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [CmdW-1:0] out_x;
   logic signed [CmdW-1:0] out_y;
   logic                   clipped;
   modport source (output valid, out_x, out_y, clipped, input ready);
   modport sink (input valid, out_x, out_y, clipped, output ready);
endinterface

interface pdvl_csr_if import pdvl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/dual_axis_pd_velocity_loop.sv @@
// ----------------------------------------------------------------------------
// Sequenced by the 13-step microprogram on one shared multiplier; with the D
// term off the derivative add is skipped. A new item is taken only once the
// sequencer is idle, even while the last response waits.
// Reset: synchronous, active high; clears gains and scales, sets
// derivative_enable, zeroes the stored errors and empties the response slot.
// ----------------------------------------------------------------------------
module dual_axis_pd_velocity_loop import pdvl_pkg::*; (
   input logic        clock,
   input logic        reset,
   pdvl_req_if.sink   req,
   pdvl_rsp_if.source rsp,
   pdvl_csr_if.sink   csr
);

   logic signed [GainW-1:0]  kp_x_ff, kp_y_ff, kd_x_ff, kd_y_ff;
   logic signed [ScaleW-1:0] scale_x_ff, scale_y_ff;
   logic                     deriv_en_ff;
   logic                     rsp_valid_ff;
   logic signed [CmdW-1:0]   rsp_x_ff, rsp_y_ff;
   logic                     rsp_clip_ff;

   logic                   start, can_finish;
   ctl_type                ctl;
   seq_stat_type           stat;
   logic signed [CmdW-1:0] dp_x, dp_y;
   logic                   dp_clip;

   assign req.ready  = !stat.busy;
   assign start      = req.valid && req.ready;
   assign can_finish = !rsp_valid_ff || rsp.ready;
   assign csr.ready  = 1'b1;

   pdvl_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .deriv_en   (deriv_en_ff),
      .can_finish (can_finish),
      .ctl        (ctl),
      .stat       (stat)
   );

   pdvl_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .ctl     (ctl),
      .cmd_x   (req.cmd_x),
      .cmd_y   (req.cmd_y),
      .vel_x   (req.vel_x),
      .vel_y   (req.vel_y),
      .kp_x    (kp_x_ff),
      .kp_y    (kp_y_ff),
      .kd_x    (kd_x_ff),
      .kd_y    (kd_y_ff),
      .scale_x (scale_x_ff),
      .scale_y (scale_y_ff),
      .out_x   (dp_x),
      .out_y   (dp_y),
      .clipped (dp_clip)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_x_ff     <= '0;
         kp_y_ff     <= '0;
         kd_x_ff     <= '0;
         kd_y_ff     <= '0;
         scale_x_ff  <= '0;
         scale_y_ff  <= '0;
         deriv_en_ff <= 1'b1;
      end else if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_KP_X:     kp_x_ff     <= csr.data[GainW-1:0];
            CSR_KP_Y:     kp_y_ff     <= csr.data[GainW-1:0];
            CSR_KD_X:     kd_x_ff     <= csr.data[GainW-1:0];
            CSR_KD_Y:     kd_y_ff     <= csr.data[GainW-1:0];
            CSR_SCALE_X:  scale_x_ff  <= csr.data[ScaleW-1:0];
            CSR_SCALE_Y:  scale_y_ff  <= csr.data[ScaleW-1:0];
            CSR_DERIV_EN: deriv_en_ff <= csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_x_ff    <= dp_x;
         rsp_y_ff    <= dp_y;
         rsp_clip_ff <= dp_clip;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_x   = rsp_x_ff;
   assign rsp.out_y   = rsp_y_ff;
   assign rsp.clipped = rsp_clip_ff;

   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (!rsp_valid_ff || rsp.ready))
      else $error("result published over a waiting response");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (stat.busy && !stat.done))
      else $error("sequencer not running after item accept");

   a_done_fills: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (rsp_valid_ff && !stat.busy))
      else $error("response slot not filled after finish");

endmodule

@@ sv/pdvl_seq.sv @@
// ----------------------------------------------------------------------------
// pdvl_seq
// Step counter over the microprogram ROM; jumps past the derivative add when
// the D term is off and holds on the final step until the response slot frees.
// ----------------------------------------------------------------------------
module pdvl_seq import pdvl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         deriv_en,
   input  logic         can_finish,
   output ctl_type      ctl,
   output seq_stat_type stat
);

   logic [StepW-1:0] step_ff, step_in;
   logic             busy_ff, busy_in;
   ctl_type          word;

   always_comb word = ucode(step_ff);

   always_comb begin
      step_in   = step_ff;
      busy_in   = busy_ff;
      stat.busy = busy_ff;
      stat.done = 1'b0;
      priority if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         priority if (word.last) begin
            if (can_finish) begin
               busy_in   = 1'b0;
               stat.done = 1'b1;
            end
         end else if (word.jmp_nod && !deriv_en) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_comb ctl = busy_ff ? word : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

@@ sv/pdvl_dp.sv @@
// ----------------------------------------------------------------------------
// pdvl_dp
// Shared multiplier, accumulator, error and output registers driven by the
// control word, with the stored previous error of each axis.
// ----------------------------------------------------------------------------
module pdvl_dp import pdvl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ctl_type                  ctl,
   input  logic signed [CmdW-1:0]   cmd_x,
   input  logic signed [CmdW-1:0]   cmd_y,
   input  logic signed [VelW-1:0]   vel_x,
   input  logic signed [VelW-1:0]   vel_y,
   input  logic signed [GainW-1:0]  kp_x,
   input  logic signed [GainW-1:0]  kp_y,
   input  logic signed [GainW-1:0]  kd_x,
   input  logic signed [GainW-1:0]  kd_y,
   input  logic signed [ScaleW-1:0] scale_x,
   input  logic signed [ScaleW-1:0] scale_y,
   output logic signed [CmdW-1:0]   out_x,
   output logic signed [CmdW-1:0]   out_y,
   output logic                     clipped
);

   logic signed [CmdW-1:0]  cmd_ff [2];
   logic signed [VelW-1:0]  vel_ff [2];
   logic signed [CmdW-1:0]  prev_ff [2];
   logic signed [CmdW-1:0]  out_ff [2];
   logic signed [CmdW-1:0]  err_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic                    clip_ff;

   logic signed [CmdW-1:0]   cmd_sel, prev_sel;
   logic signed [GainW-1:0]  kp_sel, kd_sel;
   logic signed [ScaleW-1:0] scale_sel;
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b, diff;
   logic signed [ProdW-1:0]  prod_in, prod_rnd;
   logic signed [AccW-1:0]   acc_rnd;
   logic signed [WideW-1:0]  err_wide, out_wide;
   logic [CmdW:0]            err_sat, out_sat;

   always_comb begin
      cmd_sel   = cmd_ff[ctl.axis];
      prev_sel  = prev_ff[ctl.axis];
      kp_sel    = ctl.axis ? kp_y : kp_x;
      kd_sel    = ctl.axis ? kd_y : kd_x;
      scale_sel = ctl.axis ? scale_y : scale_x;
      diff      = {err_ff[CmdW-1], err_ff} - {prev_sel[CmdW-1], prev_sel};
   end

   always_comb begin
      unique case (ctl.mul_sel)
         MUL_SCALE: begin
            mul_a = scale_sel;
            mul_b = {vel_ff[ctl.axis][VelW-1], vel_ff[ctl.axis]};
         end
         MUL_KP: begin
            mul_a = {{(MulAW-GainW){kp_sel[GainW-1]}}, kp_sel};
            mul_b = {err_ff[CmdW-1], err_ff};
         end
         MUL_KD: begin
            mul_a = {{(MulAW-GainW){kd_sel[GainW-1]}}, kd_sel};
            mul_b = diff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      prod_in  = mul_a * mul_b;
      prod_rnd = prod_ff + (ProdW'(1) <<< (FracW - 1));
      err_wide = {{(WideW-CmdW){cmd_sel[CmdW-1]}}, cmd_sel}
               - {prod_rnd[ProdW-1], prod_rnd[ProdW-1:FracW]};
      err_sat  = sat16(err_wide);
      acc_rnd  = acc_ff + (AccW'(1) <<< (FracW - 1));
      out_wide = {{(WideW-AccW+FracW){acc_rnd[AccW-1]}}, acc_rnd[AccW-1:FracW]};
      out_sat  = sat16(out_wide);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff[0] <= cmd_x;
         cmd_ff[1] <= cmd_y;
         vel_ff[0] <= vel_x;
         vel_ff[1] <= vel_y;
      end
      if (ctl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (ctl.err_load) begin
         err_ff <= err_sat[CmdW-1:0];
      end
      unique case (ctl.acc_op)
         ACC_LOAD: acc_ff <= {{(AccW-CmdW-FracW){cmd_sel[CmdW-1]}}, cmd_sel, {FracW{1'b0}}};
         ACC_ADD:  acc_ff <= acc_ff + prod_ff[AccW-1:0];
         default:  acc_ff <= acc_ff;
      endcase
      if (ctl.out_load) begin
         out_ff[ctl.axis] <= out_sat[CmdW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff[0] <= '0;
         prev_ff[1] <= '0;
         clip_ff    <= 1'b0;
      end else begin
         if (ctl.prev_load) begin
            prev_ff[ctl.axis] <= err_ff;
         end
         priority if (start) begin
            clip_ff <= 1'b0;
         end else if (ctl.err_load) begin
            clip_ff <= clip_ff | err_sat[CmdW];
         end else if (ctl.out_load) begin
            clip_ff <= clip_ff | out_sat[CmdW];
         end
      end
   end

   assign out_x   = out_ff[0];
   assign out_y   = out_ff[1];
   assign clipped = clip_ff;

endmodule

@@ tb/pdvl_correction_monitor.sv @@
// ----------------------------------------------------------------------------
// pdvl_correction_monitor
// Watches the register, request and response channels of the two-axis PD
// velocity loop. Keeps its own copy of the gains, scales and stored errors,
// predicts the corrected commands of every accepted item and compares each
// response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pdvl_correction_monitor import pdvl_pkg::*; (
   input  logic clock,
   input  logic reset,
   pdvl_req_if  req,
   pdvl_rsp_if  rsp,
   pdvl_csr_if  csr,
   output int   mismatches,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [CmdW-1:0] out;
      logic signed [CmdW-1:0] err;
      logic                   clip;
   } axis_step_type;

   typedef struct packed {
      logic signed [CmdW-1:0] out_x;
      logic signed [CmdW-1:0] out_y;
      logic                   clipped;
   } correction_type;

   longint         gain_p_x, gain_p_y, gain_d_x, gain_d_y;
   longint         scale_x, scale_y;
   bit             deriv_on;
   longint         last_err_x, last_err_y;
   correction_type corrections_due[$];
   correction_type want;
   axis_step_type  step_x, step_y;
   int             error_count;

   function automatic longint clamp_q14(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic axis_step_type correct_axis(input longint cmd, input longint vel,
                                                  input longint scale, input longint kp,
                                                  input longint kd, input longint prev,
                                                  input bit use_d);
      axis_step_type r;
      longint        scaled, err, err_sat, acc, sum, sum_sat;
      scaled  = (scale * vel + 64'sd32768) >>> 16;
      err     = cmd - scaled;
      err_sat = clamp_q14(err);
      acc     = cmd * 64'sd65536 + kp * err_sat;
      if (use_d) begin
         acc = acc + kd * (err_sat - prev);
      end
      sum     = (acc + 64'sd32768) >>> 16;
      sum_sat = clamp_q14(sum);
      r.out   = sum_sat[CmdW-1:0];
      r.err   = err_sat[CmdW-1:0];
      r.clip  = (err_sat != err) || (sum_sat != sum);
      return r;
   endfunction

   initial begin
      error_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         gain_p_x   = 0;
         gain_p_y   = 0;
         gain_d_x   = 0;
         gain_d_y   = 0;
         scale_x    = 0;
         scale_y    = 0;
         deriv_on   = 1'b1;
         last_err_x = 0;
         last_err_y = 0;
         corrections_due.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            unique case (csr_idx_type'(csr.index))
               CSR_KP_X:     gain_p_x = $signed(csr.data[GainW-1:0]);
               CSR_KP_Y:     gain_p_y = $signed(csr.data[GainW-1:0]);
               CSR_KD_X:     gain_d_x = $signed(csr.data[GainW-1:0]);
               CSR_KD_Y:     gain_d_y = $signed(csr.data[GainW-1:0]);
               CSR_SCALE_X:  scale_x  = $signed(csr.data[ScaleW-1:0]);
               CSR_SCALE_Y:  scale_y  = $signed(csr.data[ScaleW-1:0]);
               CSR_DERIV_EN: deriv_on = csr.data[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (corrections_due.size() == 0) begin
               $error("response item with no item outstanding");
               error_count++;
            end else begin
               want = corrections_due.pop_front();
               if (rsp.out_x !== want.out_x) begin
                  $error("out_x: expected %0d, got %0d", want.out_x, rsp.out_x);
                  error_count++;
               end
               if (rsp.out_y !== want.out_y) begin
                  $error("out_y: expected %0d, got %0d", want.out_y, rsp.out_y);
                  error_count++;
               end
               if (rsp.clipped !== want.clipped) begin
                  $error("clipped: expected %0d, got %0d", want.clipped, rsp.clipped);
                  error_count++;
               end
            end
         end
         if (req.valid && req.ready) begin
            step_x = correct_axis(req.cmd_x, req.vel_x, scale_x, gain_p_x, gain_d_x,
                                  last_err_x, deriv_on);
            step_y = correct_axis(req.cmd_y, req.vel_y, scale_y, gain_p_y, gain_d_y,
                                  last_err_y, deriv_on);
            if (deriv_on) begin
               last_err_x = step_x.err;
               last_err_y = step_y.err;
            end
            want.out_x   = step_x.out;
            want.out_y   = step_y.out;
            want.clipped = step_x.clip | step_y.clip;
            corrections_due.push_back(want);
         end
      end
      outstanding <= corrections_due.size();
      mismatches  <= error_count;
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the two-axis PD velocity loop: directed items for
// rounding, error and output saturation and the derivative switch, then
// random register settings and items under varying sender and receiver
// idling, including a long receiver stall that backs up the request side.
// ----------------------------------------------------------------------------
module testbench import pdvl_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrIdxW-1:0] CsrSpareIdx = 3'd7;
   localparam int StallLimit   = 2000;
   localparam int HoldOffCount = 300;
   localparam int SettleCycles = 20;

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   int   sender_idle_pct;
   int   receiver_idle_pct;
   bit   hold_off_request;
   int   quiet_cycles;

   pdvl_req_if req_ch ();
   pdvl_rsp_if rsp_ch ();
   pdvl_csr_if csr_ch ();

   dual_axis_pd_velocity_loop u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   pdvl_correction_monitor u_monitor (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [GainW-1:0] pick_gain();
      unique case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return '0;
         3: return 24'($urandom);
         default: return 24'($urandom_range(262144) - 131072);
      endcase
   endfunction

   function automatic logic [ScaleW-1:0] pick_scale();
      unique case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'($urandom);
         default: return 32'($urandom_range(1048576) - 524288);
      endcase
   endfunction

   function automatic logic [CmdW-1:0] pick_cmd();
      if ($urandom_range(9) < 7) return 16'($urandom_range(16384) - 8192);
      return 16'($urandom);
   endfunction

   function automatic logic [VelW-1:0] pick_vel();
      if ($urandom_range(9) < 6) return 16'($urandom_range(4000) - 2000);
      return 16'($urandom);
   endfunction

   task automatic offer_sample(input logic [CmdW-1:0] cx, input logic [CmdW-1:0] cy,
                               input logic [VelW-1:0] vx, input logic [VelW-1:0] vy);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd_x <= cx;
      req_ch.cmd_y <= cy;
      req_ch.vel_x <= vx;
      req_ch.vel_y <= vy;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_until_settled();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CsrIdxW-1:0] idx,
                                 input logic [CsrDataW-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_deriv_enable(input bit on);
      write_register(CSR_DERIV_EN, (32'($urandom) & ~32'd1) | 32'(on));
   endtask

   task automatic load_settings(input logic [GainW-1:0] kpx, input logic [GainW-1:0] kpy,
                                input logic [GainW-1:0] kdx, input logic [GainW-1:0] kdy,
                                input logic [ScaleW-1:0] sx, input logic [ScaleW-1:0] sy,
                                input bit on);
      wait_until_settled();
      write_register(CSR_KP_X, {8'($urandom), kpx});
      write_register(CSR_KP_Y, {8'($urandom), kpy});
      write_register(CSR_KD_X, {8'($urandom), kdx});
      write_register(CSR_KD_Y, {8'($urandom), kdy});
      write_register(CSR_SCALE_X, sx);
      write_register(CSR_SCALE_Y, sy);
      write_deriv_enable(on);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      @(posedge clock);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldOffCount) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.cmd_x      = '0;
      req_ch.cmd_y      = '0;
      req_ch.vel_x      = '0;
      req_ch.vel_y      = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      hold_off_request  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: outputs follow the command
      offer_sample(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      offer_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);

      load_settings(24'h010000, 24'hff0000, 24'h008000, 24'h020000,
                    32'h0000_8000, 32'h4000_0000, 1'b1);
      // scaled velocity exactly half an LSB: round up
      offer_sample(16'd0, 16'd0, 16'd1, 16'd0);
      offer_sample(16'd0, 16'd0, 16'hffff, 16'd0);
      offer_sample(16'd100, 16'h8000, 16'd3, 16'd2);
      offer_sample(16'hff9c, 16'h7fff, 16'hfffd, 16'hfffe);
      offer_sample(16'h7fff, 16'd0, 16'hffff, 16'd0);
      offer_sample(16'h8000, 16'd0, 16'd1, 16'd0);
      offer_sample(16'd1234, 16'hfb2e, 16'd0, 16'd0);
      offer_sample(16'd1234, 16'hfb2e, 16'd0, 16'd0);

      // proportional only: stored errors hold across the gap
      wait_until_settled();
      write_deriv_enable(1'b0);
      offer_sample(16'd5000, 16'hec78, 16'd10, 16'hfff6);
      offer_sample(16'hec78, 16'd5000, 16'hfff6, 16'd10);
      wait_until_settled();
      write_deriv_enable(1'b1);
      offer_sample(16'd5000, 16'hec78, 16'd10, 16'hfff6);

      // write to an index past the register list: no effect
      wait_until_settled();
      write_register(CsrSpareIdx, 32'hffff_ffff);
      offer_sample(16'd0, 16'd0, 16'd0, 16'd0);

      load_settings(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000,
                    32'h8000_0000, 32'h7fff_ffff, 1'b1);
      offer_sample(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      offer_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      offer_sample(16'd0, 16'd0, 16'd0, 16'd0);
      offer_sample(16'd1, 16'hffff, 16'd1, 16'hffff);
      offer_sample(16'hffff, 16'd1, 16'hffff, 16'd1);
      offer_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);

      for (int mode = 0; mode < 3; mode++) begin
         unique case (mode)
            0: set_idling(37, 72);
            1: set_idling(72, 37);
            default: set_idling(0, 0);
         endcase
         for (int setting = 0; setting < 4; setting++) begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                          pick_scale(), pick_scale(), $urandom_range(9) < 7);
            if (mode == 2 && setting == 0) begin
               @(posedge clock);
               hold_off_request = 1'b1;
            end
            repeat (117) offer_sample(pick_cmd(), pick_cmd(), pick_vel(), pick_vel());
         end
      end

      wait_until_settled();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
